@@ hdl/rtwa_pkg.sv @@
// Shared types and constants of the runqueue time-weighted average block.
package rtwa_pkg;

   localparam int NUM_CPUS_DEF = 8;
   localparam int AVG_W        = 31;
   localparam int MASK_W       = 8;
   localparam int NUM_W        = 71;
   localparam int DIV_STEPS    = NUM_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
   localparam logic [6:0] SCALE = 7'd100;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_UPD   = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_WALK  = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic query_commit;
      logic emit_zero;
      logic walk_step;
      logic scale;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic span_zero;
      logic walk_last;
      logic div_last;
      logic fault;
   } status_type;

endpackage

@@ hdl/rtwa_ctrl.sv @@
// Controller state machine: sequences update, CPU walk, scaling and division.
module rtwa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_func,
   input  rtwa_pkg::status_type status,
   output rtwa_pkg::cmd_type   cmd,
   output logic                busy
);

   rtwa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtwa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         rtwa_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_func == rtwa_pkg::FUNC_QUERY) ? rtwa_pkg::ST_CHECK
                                                             : rtwa_pkg::ST_UPD;
            end
         end
         rtwa_pkg::ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = rtwa_pkg::ST_IDLE;
         end
         rtwa_pkg::ST_CHECK: begin
            if (status.span_zero) begin
               cmd.emit_zero = 1'b1;
               state_in      = rtwa_pkg::ST_IDLE;
            end else begin
               cmd.query_commit = 1'b1;
               state_in         = rtwa_pkg::ST_WALK;
            end
         end
         rtwa_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = rtwa_pkg::ST_SCALE;
            end
         end
         rtwa_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = status.fault ? rtwa_pkg::ST_DONE : rtwa_pkg::ST_DIV;
         end
         rtwa_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = rtwa_pkg::ST_DONE;
            end
         end
         rtwa_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = rtwa_pkg::ST_IDLE;
         end
         default: begin
            state_in = rtwa_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != rtwa_pkg::ST_IDLE);

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && status.div_last |=> state_ff == rtwa_pkg::ST_DONE)
      else $error("division end missed");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy)
      else $error("not busy after accept");

endmodule

@@ hdl/rtwa_datapath.sv @@
// Datapath: per-CPU state, interval accumulation, scaling and bit-serial division.
module rtwa_datapath #(
   parameter int NUM_CPUS = rtwa_pkg::NUM_CPUS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rtwa_pkg::cmd_type           cmd,
   output rtwa_pkg::status_type        status,
   input  logic [63:0]                 req_timestamp,
   input  logic [2:0]                  req_cpu_index,
   input  logic [9:0]                  req_running_count,
   input  logic                        req_increment,
   input  logic [9:0]                  req_iowait_count,
   output logic                        rsp_valid,
   output logic [rtwa_pkg::AVG_W-1:0]  rsp_run_average,
   output logic [rtwa_pkg::AVG_W-1:0]  rsp_iowait_average,
   output logic                        rsp_clock_fault,
   output logic [rtwa_pkg::MASK_W-1:0] rsp_fault_mask
);

   localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int NW    = rtwa_pkg::NUM_W;

   logic [63:0] stamp_ff  [NUM_CPUS];
   logic [63:0] run_sum_ff[NUM_CPUS];
   logic [63:0] io_sum_ff [NUM_CPUS];
   logic [10:0] count_ff  [NUM_CPUS];
   logic [9:0]  io_lat_ff [NUM_CPUS];
   logic [63:0] last_q_ff;

   logic [63:0] now_ff, span_ff;
   logic [2:0]  cpu_ff;
   logic [9:0]  run_ff, io_ff;
   logic        inc_ff;

   logic [IDX_W-1:0] walk_idx_ff;
   logic [63:0] tot_run_ff, tot_io_ff;
   logic        fault_ff;
   logic [rtwa_pkg::MASK_W-1:0] mask_ff;

   logic [NW-1:0] num_run_ff, num_io_ff;
   logic [63:0]   rem_run_ff, rem_io_ff;
   logic [rtwa_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   logic [rtwa_pkg::AVG_W-1:0] run_avg_ff, io_avg_ff;
   logic        rsp_valid_ff, rsp_fault_ff;
   logic [rtwa_pkg::MASK_W-1:0] rsp_mask_ff;

   logic [IDX_W-1:0] rd_idx;
   logic [63:0] dt, prod_cnt, prod_lat, prod_run_upd, prod_io_upd;
   logic        behind, upd_ok;
   logic [10:0] count_in;
   logic [64:0] trial_run, trial_io, span_x;
   logic        ge_run, ge_io;
   logic [63:0] rem_run_in, rem_io_in;

   always_comb begin
      rd_idx       = cmd.walk_step ? walk_idx_ff : IDX_W'(cpu_ff);
      dt           = now_ff - stamp_ff[rd_idx];
      behind       = dt[63];
      upd_ok       = (int'(cpu_ff) < NUM_CPUS);
      prod_cnt     = {53'b0, count_ff[rd_idx]} * dt;
      prod_lat     = {54'b0, io_lat_ff[rd_idx]} * dt;
      prod_run_upd = {54'b0, run_ff} * dt;
      prod_io_upd  = {54'b0, io_ff} * dt;
      if (inc_ff) begin
         count_in = {1'b0, run_ff} + 11'd1;
      end else if (run_ff != 10'd0) begin
         count_in = {1'b0, run_ff} - 11'd1;
      end else begin
         count_in = 11'd0;
      end
      span_x     = {1'b0, span_ff};
      trial_run  = {rem_run_ff, num_run_ff[NW-1]};
      trial_io   = {rem_io_ff, num_io_ff[NW-1]};
      ge_run     = (trial_run >= span_x);
      ge_io      = (trial_io >= span_x);
      rem_run_in = ge_run ? 64'(trial_run - span_x) : trial_run[63:0];
      rem_io_in  = ge_io ? 64'(trial_io - span_x) : trial_io[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            stamp_ff[c]   <= '0;
            run_sum_ff[c] <= '0;
            io_sum_ff[c]  <= '0;
            count_ff[c]   <= '0;
            io_lat_ff[c]  <= '0;
         end
         last_q_ff    <= '0;
         walk_idx_ff  <= '0;
         fault_ff     <= 1'b0;
         mask_ff      <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit | cmd.emit_zero;
         if (cmd.load) begin
            now_ff      <= req_timestamp;
            span_ff     <= req_timestamp - last_q_ff;
            cpu_ff      <= req_cpu_index;
            run_ff      <= req_running_count;
            inc_ff      <= req_increment;
            io_ff       <= req_iowait_count;
            walk_idx_ff <= '0;
            tot_run_ff  <= '0;
            tot_io_ff   <= '0;
            fault_ff    <= 1'b0;
            mask_ff     <= '0;
         end
         if (cmd.update && upd_ok && !behind) begin
            stamp_ff[rd_idx]   <= now_ff;
            count_ff[rd_idx]   <= count_in;
            run_sum_ff[rd_idx] <= run_sum_ff[rd_idx] + prod_run_upd;
            io_sum_ff[rd_idx]  <= io_sum_ff[rd_idx] + prod_io_upd;
            io_lat_ff[rd_idx]  <= io_ff;
         end
         if (cmd.query_commit) begin
            last_q_ff <= now_ff;
         end
         if (cmd.walk_step) begin
            tot_run_ff         <= tot_run_ff + run_sum_ff[rd_idx] + prod_cnt;
            tot_io_ff          <= tot_io_ff + io_sum_ff[rd_idx] + prod_lat;
            stamp_ff[rd_idx]   <= now_ff;
            run_sum_ff[rd_idx] <= '0;
            io_sum_ff[rd_idx]  <= '0;
            if (behind) begin
               fault_ff <= 1'b1;
               if (int'(walk_idx_ff) < rtwa_pkg::MASK_W) begin
                  mask_ff[3'(walk_idx_ff)] <= 1'b1;
               end
            end
            if (!status.walk_last) begin
               walk_idx_ff <= walk_idx_ff + IDX_W'(1);
            end
         end
         if (cmd.scale) begin
            num_run_ff <= {7'b0, tot_run_ff} * {64'b0, rtwa_pkg::SCALE};
            num_io_ff  <= {7'b0, tot_io_ff} * {64'b0, rtwa_pkg::SCALE};
            rem_run_ff <= '0;
            rem_io_ff  <= '0;
            div_cnt_ff <= '0;
         end
         if (cmd.div_step) begin
            rem_run_ff <= rem_run_in;
            rem_io_ff  <= rem_io_in;
            num_run_ff <= {num_run_ff[NW-2:0], ge_run};
            num_io_ff  <= {num_io_ff[NW-2:0], ge_io};
            div_cnt_ff <= div_cnt_ff + rtwa_pkg::DIV_CNT_W'(1);
         end
         if (cmd.emit_zero) begin
            run_avg_ff   <= '0;
            io_avg_ff    <= '0;
            rsp_fault_ff <= 1'b0;
            rsp_mask_ff  <= '0;
         end
         if (cmd.emit) begin
            rsp_fault_ff <= fault_ff;
            rsp_mask_ff  <= mask_ff;
            if (fault_ff) begin
               run_avg_ff <= '0;
               io_avg_ff  <= '0;
            end else begin
               run_avg_ff <= (|num_run_ff[NW-1:rtwa_pkg::AVG_W]) ? rtwa_pkg::AVG_MAX
                                                                 : num_run_ff[rtwa_pkg::AVG_W-1:0];
               io_avg_ff  <= (|num_io_ff[NW-1:rtwa_pkg::AVG_W]) ? rtwa_pkg::AVG_MAX
                                                                : num_io_ff[rtwa_pkg::AVG_W-1:0];
            end
         end
      end
   end

   assign status.span_zero = (span_ff == 64'd0);
   assign status.walk_last = (walk_idx_ff == IDX_W'(NUM_CPUS - 1));
   assign status.div_last  = (div_cnt_ff == rtwa_pkg::DIV_CNT_W'(rtwa_pkg::DIV_STEPS - 1));
   assign status.fault     = fault_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_run_average    = run_avg_ff;
   assign rsp_iowait_average = io_avg_ff;
   assign rsp_clock_fault    = rsp_fault_ff;
   assign rsp_fault_mask     = rsp_mask_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clock_fault |-> rsp_run_average == '0 && rsp_iowait_average == '0)
      else $error("nonzero average with clock fault");
   a_mask_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fault_mask != '0) |-> rsp_clock_fault)
      else $error("fault mask without fault flag");

endmodule

@@ hdl/runqueue_time_weighted_average.sv @@
// Top level of the runqueue time-weighted average block.
// Use: drive req_* with start high while busy is low; that cycle's edge accepts the
// transaction. req_func 0 is a per-CPU update, req_func 1 a query.
// An update gives no result and holds busy for one cycle after acceptance.
// A query gives exactly one result: rsp_valid pulses for one cycle with
// rsp_run_average, rsp_iowait_average, rsp_clock_fault and rsp_fault_mask.
// Query: with zero elapsed time the check state emits a zero result; otherwise
// the controller walks every CPU entry, scales the totals and runs the
// bit-serial divider, which handles both averages side by side. A clock
// fault skips the divider.
// Throughput: one transaction at a time; start is ignored while busy.
// Reset (synchronous, active high) clears all per-CPU stamps, sums and counts
// and the last query stamp, and returns the controller to idle.
// The receiver cannot stall; result fields hold until the next result.
module runqueue_time_weighted_average #(
   parameter int NUM_CPUS = rtwa_pkg::NUM_CPUS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic [63:0]                 req_timestamp,
   input  logic [2:0]                  req_cpu_index,
   input  logic [9:0]                  req_running_count,
   input  logic                        req_increment,
   input  logic [9:0]                  req_iowait_count,
   output logic                        rsp_valid,
   output logic [rtwa_pkg::AVG_W-1:0]  rsp_run_average,
   output logic [rtwa_pkg::AVG_W-1:0]  rsp_iowait_average,
   output logic                        rsp_clock_fault,
   output logic [rtwa_pkg::MASK_W-1:0] rsp_fault_mask
);

   rtwa_pkg::cmd_type    cmd;
   rtwa_pkg::status_type status;

   rtwa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   rtwa_datapath #(
      .NUM_CPUS (NUM_CPUS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_timestamp      (req_timestamp),
      .req_cpu_index      (req_cpu_index),
      .req_running_count  (req_running_count),
      .req_increment      (req_increment),
      .req_iowait_count   (req_iowait_count),
      .rsp_valid          (rsp_valid),
      .rsp_run_average    (rsp_run_average),
      .rsp_iowait_average (rsp_iowait_average),
      .rsp_clock_fault    (rsp_clock_fault),
      .rsp_fault_mask     (rsp_fault_mask)
   );

endmodule
